// File: rtl/stt_pkg.sv
// Shared types, token kind codes and keyword table for the source text tokenizer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package stt_pkg;

  // Text limit sets the largest byte offset that a token can report.
  localparam longint unsigned TEXT_LIMIT    = 64'd65536;
  localparam int unsigned     KEYWORD_BYTES = 5;
  localparam logic [15:0]     SAT16         = 16'hFFFF;
  localparam logic [15:0]     POS_MAX       = (TEXT_LIMIT - 64'd1 > 64'd65535) ? 16'hFFFF :
                                              16'(TEXT_LIMIT - 64'd1);

  // Depth of the queue between scanner and output stage.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Token kind codes.
  localparam logic [4:0] KIND_END     = 5'd0;
  localparam logic [4:0] KIND_ERROR   = 5'd1;
  localparam logic [4:0] KIND_IDENT   = 5'd2;
  localparam logic [4:0] KIND_INTEGER = 5'd3;
  localparam logic [4:0] KIND_BOOL    = 5'd4;
  localparam logic [4:0] KIND_LET     = 5'd5;
  localparam logic [4:0] KIND_IF      = 5'd6;
  localparam logic [4:0] KIND_ELSE    = 5'd7;
  localparam logic [4:0] KIND_WHILE   = 5'd8;
  localparam logic [4:0] KIND_PRINT   = 5'd9;
  localparam logic [4:0] KIND_INPUT   = 5'd10;
  localparam logic [4:0] KIND_PLUS    = 5'd11;
  localparam logic [4:0] KIND_MINUS   = 5'd12;
  localparam logic [4:0] KIND_STAR    = 5'd13;
  localparam logic [4:0] KIND_SLASH   = 5'd14;
  localparam logic [4:0] KIND_LPAREN  = 5'd15;
  localparam logic [4:0] KIND_RPAREN  = 5'd16;
  localparam logic [4:0] KIND_LBRACE  = 5'd17;
  localparam logic [4:0] KIND_RBRACE  = 5'd18;
  localparam logic [4:0] KIND_SEMI    = 5'd19;
  localparam logic [4:0] KIND_ASSIGN  = 5'd20;
  localparam logic [4:0] KIND_EQ      = 5'd21;
  localparam logic [4:0] KIND_NOT     = 5'd22;
  localparam logic [4:0] KIND_NE      = 5'd23;
  localparam logic [4:0] KIND_LT      = 5'd24;
  localparam logic [4:0] KIND_LE      = 5'd25;
  localparam logic [4:0] KIND_GT      = 5'd26;
  localparam logic [4:0] KIND_GE      = 5'd27;

  // Keyword table: text, length and kind of each reserved word.
  localparam int unsigned KW_COUNT = 8;
  localparam int unsigned KW_MAXLEN = 5;
  localparam logic [7:0] KW_TXT [KW_COUNT][KW_MAXLEN] = '{
    '{"l", "e", "t", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00},
    '{"w", "h", "i", "l", "e"},
    '{"p", "r", "i", "n", "t"},
    '{"i", "n", "p", "u", "t"},
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"}
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5};
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{KIND_LET, KIND_IF, KIND_ELSE, KIND_WHILE,
                                                KIND_PRINT, KIND_INPUT, KIND_BOOL, KIND_BOOL};

  typedef logic [KEYWORD_BYTES-1:0][7:0] prefix_t;

  // One token as it leaves the block.
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic [7:0]  bad;
  } token_t;

  // All tokens that one input beat causes: one or two.
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  // Kind of a pending one-character operator.
  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      "!":     k = KIND_NOT;
      "<":     k = KIND_LT;
      ">":     k = KIND_GT;
      default: k = KIND_ASSIGN;
    endcase
    return k;
  endfunction

  // Kind of a finished identifier: a keyword, a boolean literal or a plain name.
  // Prefix bytes are only looked at when the length matches, so every byte read was written.
  function automatic logic [4:0] ident_kind(input prefix_t prefix, input logic [15:0] size);
    logic [4:0] k;
    logic       found;
    logic       same;
    k     = KIND_IDENT;
    found = 1'b0;
    for (int w = 0; w < KW_COUNT; w++) begin
      if (!found && size == 16'(KW_LEN[w]) && int'(KW_LEN[w]) <= KEYWORD_BYTES) begin
        same = 1'b1;
        for (int i = 0; i < KW_MAXLEN; i++) begin
          if (i < int'(KW_LEN[w]) && prefix[i] != KW_TXT[w][i]) begin
            same = 1'b0;
          end
        end
        if (same) begin
          k     = KW_KIND[w];
          found = 1'b1;
        end
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/stt_front.sv
// Scanner front end: accepts one byte per beat, tracks scan state and builds token entries.
// Depends on stt_pkg; feeds stt_queue.
`default_nettype none

module stt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      char_code_i,
  input  logic            end_of_text_i,
  input  logic            full_i,
  output logic            push_o,
  output stt_pkg::entry_t entry_o
);
  import stt_pkg::*;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUM     = 3'd2;
  localparam logic [2:0] MODE_OP      = 3'd3;
  localparam logic [2:0] MODE_SLASH   = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_ERROR   = 3'd6;

  logic [2:0]  mode_q, mode_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] line_q, line_d;
  logic [15:0] begin_q, begin_d;
  logic [15:0] size_q, size_d;
  logic [7:0]  pend_op_q, pend_op_d;
  prefix_t     prefix_q;

  logic       accept;
  logic [7:0] c;
  logic       is_digit, is_alpha, is_word, is_blank, is_nl;

  // What a byte does when it opens a fresh token.
  logic [2:0] sb_mode;
  logic       sb_line_inc;
  logic       sb_begin;
  logic       sb_size1;
  logic       sb_pend_op;
  logic       sb_pref0;
  logic       sb_tok_v;
  token_t     sb_tok;
  logic [4:0] simple_kind;

  // The pending token that the current byte closes.
  logic   pend_v;
  token_t pend_tok;

  logic   a_v, b_v;
  token_t a_tok, b_tok;
  logic   do_start;
  logic   grow_ident;
  logic   grow_any;

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign c          = char_code_i;

  // Character classes.
  always_comb begin
    is_digit = (c >= "0") && (c <= "9");
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    is_word  = is_alpha || is_digit || (c == "_");
    is_nl    = (c == 8'h0A);
    is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  end

  // Single-byte operators that are complete at once.
  always_comb begin
    case (c)
      "+":     simple_kind = KIND_PLUS;
      "-":     simple_kind = KIND_MINUS;
      "*":     simple_kind = KIND_STAR;
      "(":     simple_kind = KIND_LPAREN;
      ")":     simple_kind = KIND_RPAREN;
      "{":     simple_kind = KIND_LBRACE;
      "}":     simple_kind = KIND_RBRACE;
      ";":     simple_kind = KIND_SEMI;
      default: simple_kind = KIND_END;
    endcase
  end

  // Classification of a byte that starts something new.
  always_comb begin
    sb_mode      = MODE_IDLE;
    sb_line_inc  = 1'b0;
    sb_begin     = 1'b0;
    sb_size1     = 1'b0;
    sb_pend_op   = 1'b0;
    sb_pref0     = 1'b0;
    sb_tok_v     = 1'b0;
    sb_tok       = '0;
    sb_tok.start = pos_q;
    sb_tok.len   = 16'd1;
    sb_tok.line  = line_q;
    if (is_nl) begin
      sb_line_inc = 1'b1;
    end else if (is_blank) begin
      sb_mode = MODE_IDLE;
    end else if (is_digit) begin
      sb_mode  = MODE_NUM;
      sb_begin = 1'b1;
      sb_size1 = 1'b1;
    end else if (is_alpha || c == "_") begin
      sb_mode  = MODE_IDENT;
      sb_begin = 1'b1;
      sb_size1 = 1'b1;
      sb_pref0 = 1'b1;
    end else if (c == "/") begin
      sb_mode  = MODE_SLASH;
      sb_begin = 1'b1;
    end else if (c == "=" || c == "!" || c == "<" || c == ">") begin
      sb_mode    = MODE_OP;
      sb_begin   = 1'b1;
      sb_pend_op = 1'b1;
    end else if (simple_kind != KIND_END) begin
      sb_tok_v    = 1'b1;
      sb_tok.kind = simple_kind;
    end else begin
      sb_tok_v    = 1'b1;
      sb_tok.kind = KIND_ERROR;
      sb_tok.bad  = c;
      sb_mode     = MODE_ERROR;
    end
  end

  // Token that a closing byte or the end marker flushes.
  always_comb begin
    pend_v         = 1'b0;
    pend_tok       = '0;
    pend_tok.start = begin_q;
    pend_tok.line  = line_q;
    pend_tok.len   = size_q;
    case (mode_q)
      MODE_IDENT: begin
        pend_v        = 1'b1;
        pend_tok.kind = ident_kind(prefix_q, size_q);
      end
      MODE_NUM: begin
        pend_v        = 1'b1;
        pend_tok.kind = KIND_INTEGER;
      end
      MODE_OP: begin
        pend_v        = 1'b1;
        pend_tok.kind = op_kind(pend_op_q);
        pend_tok.len  = 16'd1;
      end
      MODE_SLASH: begin
        pend_v        = 1'b1;
        pend_tok.kind = KIND_SLASH;
        pend_tok.len  = 16'd1;
      end
      default: pend_v = 1'b0;
    endcase
  end

  // Next state and the tokens of this beat.
  always_comb begin
    mode_d     = mode_q;
    pos_d      = pos_q;
    line_d     = line_q;
    begin_d    = begin_q;
    size_d     = size_q;
    pend_op_d  = pend_op_q;
    a_v        = 1'b0;
    a_tok      = pend_tok;
    b_v        = 1'b0;
    b_tok      = sb_tok;
    do_start   = 1'b0;
    grow_ident = 1'b0;
    grow_any   = 1'b0;

    if (end_of_text_i) begin
      a_v        = pend_v;
      b_v        = 1'b1;
      b_tok      = '0;
      b_tok.kind = KIND_END;
      b_tok.start = pos_q;
      b_tok.line = line_q;
      mode_d     = MODE_IDLE;
      pos_d      = '0;
      line_d     = 16'd1;
      begin_d    = '0;
      size_d     = '0;
      pend_op_d  = '0;
    end else begin
      case (mode_q)
        MODE_IDENT: begin
          if (is_word) begin
            grow_ident = 1'b1;
            grow_any   = 1'b1;
          end else begin
            do_start = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit) grow_any = 1'b1;
          else          do_start = 1'b1;
        end
        MODE_OP: begin
          if (c == "=") begin
            a_v        = 1'b1;
            a_tok.kind = op_kind(pend_op_q) + 5'd1;
            a_tok.len  = 16'd2;
            mode_d     = MODE_IDLE;
          end else begin
            do_start = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (c == "/") mode_d   = MODE_COMMENT;
          else          do_start = 1'b1;
        end
        MODE_COMMENT: begin
          if (is_nl) begin
            if (line_q < SAT16) line_d = line_q + 16'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_ERROR: mode_d = MODE_ERROR;
        default:    do_start = 1'b1;
      endcase

      if (grow_any && size_q < SAT16) size_d = size_q + 16'd1;

      if (do_start) begin
        a_v    = pend_v;
        b_v    = sb_tok_v;
        mode_d = sb_mode;
        if (sb_line_inc && line_q < SAT16) line_d = line_q + 16'd1;
        if (sb_begin)   begin_d   = pos_q;
        if (sb_size1)   size_d    = 16'd1;
        if (sb_pend_op) pend_op_d = c;
      end

      if (pos_q < POS_MAX) pos_d = pos_q + 16'd1;
    end
  end

  // Pack the beat's tokens in order.
  always_comb begin
    entry_o.two  = a_v && b_v;
    entry_o.tok0 = a_v ? a_tok : b_tok;
    entry_o.tok1 = b_tok;
  end

  assign push_o = accept && (a_v || b_v);

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      pos_q     <= '0;
      line_q    <= 16'd1;
      begin_q   <= '0;
      size_q    <= '0;
      pend_op_q <= '0;
    end else if (accept) begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      line_q    <= line_d;
      begin_q   <= begin_d;
      size_q    <= size_d;
      pend_op_q <= pend_op_d;
    end
  end

  // Leading bytes of the current identifier; never cleared.
  always_ff @(posedge clk_i) begin
    if (accept && !end_of_text_i) begin
      for (int j = 0; j < KEYWORD_BYTES; j++) begin
        if (grow_ident && size_q == 16'(j)) prefix_q[j] <= c;
      end
      if (do_start && sb_pref0) prefix_q[0] <= c;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stt_queue.sv
// Short FIFO of token entries between the scanner and the output stage.
// Depends on stt_pkg.
`default_nettype none

module stt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stt_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output stt_pkg::entry_t entry_o
);
  import stt_pkg::*;

  entry_t              store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = store_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (!do_push && do_pop) count_q <= count_q - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wr_ptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

// File: rtl/stt_back.sv
// Output stage: takes one entry at a time and sends its tokens one beat each.
// Depends on stt_pkg; fed by stt_queue.
`default_nettype none

module stt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  stt_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output stt_pkg::token_t tok_o,
  output logic            last_o
);
  import stt_pkg::*;

  entry_t cur_q;
  logic   valid_q;
  logic   phase_q;
  logic   done;
  logic   load;

  // The entry is finished when its final token goes out.
  assign done  = phase_q || !cur_q.two;
  assign load  = !valid_q || (out_ready_i && done);
  assign pop_o = load && !empty_i;

  assign out_valid_o = valid_q;
  assign tok_o       = phase_q ? cur_q.tok1 : cur_q.tok0;
  assign last_o      = done;

  // Control: entry held and which of its tokens is shown.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      phase_q <= 1'b0;
    end else if (out_ready_i) begin
      phase_q <= 1'b1;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= entry_i;
  end

endmodule

`default_nettype wire

// File: rtl/source_text_tokenizer.sv
// Source text tokenizer: one byte per beat in, one token per beat out.
// Path: a completed token is written into the queue, then loaded into the output stage register.
// Throughput: one byte per cycle while the queue is not full; output runs one token per cycle while
// out_ready_i is high, so a byte that causes two tokens holds the output while a four-entry queue absorbs it.
// Reset: asynchronous, clears scan state (not the identifier prefix), queue pointers and output valid.
// Top level; instantiates stt_front, stt_queue and stt_back, uses stt_pkg.
`default_nettype none

module source_text_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [15:0] line_number_o,
  output logic [7:0]  bad_byte_o,
  output logic        last_of_run_o
);
  import stt_pkg::*;

  logic   push, full, pop, empty;
  entry_t front_entry, queue_entry;
  token_t tok;

  stt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .end_of_text_i(end_of_text_i),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (front_entry)
  );

  stt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(front_entry),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .entry_o(queue_entry)
  );

  stt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .entry_i    (queue_entry),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .tok_o      (tok),
    .last_o     (last_of_run_o)
  );

  // Break the token out onto its ports.
  assign token_kind_o   = tok.kind;
  assign start_offset_o = tok.start;
  assign token_length_o = tok.len;
  assign line_number_o  = tok.line;
  assign bad_byte_o     = tok.bad;

endmodule

`default_nettype wire

// File: rtl/stt_checker.sv
// Port-level checks for the source text tokenizer, attached by a bind statement.
// Depends on stt_pkg for the token kind codes.
`default_nettype none

module stt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  token_kind_o,
  input logic [15:0] start_offset_o,
  input logic [15:0] token_length_o,
  input logic [15:0] line_number_o,
  input logic [7:0]  bad_byte_o,
  input logic        last_of_run_o
);
  import stt_pkg::*;

  // A stalled output beat holds its token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
    $stable(start_offset_o) && $stable(token_length_o) && $stable(last_of_run_o))
    else $error("stalled token changed");

  // The end token is empty and always closes its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_END |-> token_length_o == 16'd0 && last_of_run_o)
    else $error("malformed end token");

  // Only error tokens carry an offending byte, and they are one byte long.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (bad_byte_o != 8'd0) |-> token_kind_o == KIND_ERROR &&
    token_length_o == 16'd1)
    else $error("bad byte on a non-error token");

  // Line numbers count from one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o != 16'd0)
    else $error("line number zero");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

`default_nettype wire
